// ----- rtl/core/escaped_frame_deframer_crc_check_macros.svh -----
// assertion helpers for the frame deframer
`ifndef ESCAPED_FRAME_DEFRAMER_CRC_CHECK_MACROS_SVH
`define ESCAPED_FRAME_DEFRAMER_CRC_CHECK_MACROS_SVH

// same-cycle implication
`define EFD_ASSERT_IMPL(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define EFD_ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- rtl/core/efd_pkg.sv -----
package efd_pkg;

	localparam int unsigned MAX_PAYLOAD_DEFAULT = 1024;
	localparam int unsigned ID_BYTES_DEFAULT    = 1;

	localparam logic [31:0] CRC_POLY  = 32'h04C1_1DB7;
	localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
	localparam logic [16:0] COUNT_MAX = 17'h1_FFFF;

	localparam int unsigned NUM_CFG = 6;

	typedef enum logic [2:0] {
		CFG_BEGIN_BYTE  = 3'd0,
		CFG_END_BYTE    = 3'd1,
		CFG_ESCAPE_BYTE = 3'd2,
		CFG_BEGIN_CODE  = 3'd3,
		CFG_END_CODE    = 3'd4,
		CFG_ESCAPE_CODE = 3'd5
	} cfg_index_t;

	localparam logic [7:0] BEGIN_BYTE_RST  = 8'd2;
	localparam logic [7:0] END_BYTE_RST    = 8'd3;
	localparam logic [7:0] ESCAPE_BYTE_RST = 8'd27;
	localparam logic [7:0] BEGIN_CODE_RST  = 8'd34;
	localparam logic [7:0] END_CODE_RST    = 8'd35;
	localparam logic [7:0] ESCAPE_CODE_RST = 8'd59;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_SHORT    = 3'd1,
		ST_BAD_ESC  = 3'd2,
		ST_BEGIN    = 3'd3,
		ST_TOO_LONG = 3'd4,
		ST_EXTRA    = 3'd5,
		ST_CRC_BAD  = 3'd6
	} status_t;

	typedef enum logic {
		KIND_DATA   = 1'b0,
		KIND_STATUS = 1'b1
	} kind_t;

	// msb-first crc-32 update over one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {b, 24'h0};
		for (int k = 0; k < 8; k++) begin
			c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// ----- rtl/core/escaped_frame_deframer_crc_check.sv -----
// path from input transfer to result: the input register, then the result register
// throughput: one raw byte per cycle while no result is stalled; bytes that yield no result still advance
// a stalled result holds the input register and the frame state, the next byte waits behind it
// reset: asynchronous, active low; hunting for begin, registers back to defaults
`include "escaped_frame_deframer_crc_check_macros.svh"

module escaped_frame_deframer_crc_check #(
	parameter int unsigned MAX_PAYLOAD = efd_pkg::MAX_PAYLOAD_DEFAULT,
	parameter int unsigned ID_BYTES    = efd_pkg::ID_BYTES_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [7:0]  data_byte,
	output logic [7:0]  sender_id,
	output logic [7:0]  receiver_id,
	output logic [15:0] payload_len,
	output logic [2:0]  status
);

	localparam int unsigned HDR_LEN = 2 * ID_BYTES + 2;
	localparam logic [16:0] HDR_LEN_C = 17'(HDR_LEN);
	localparam logic [16:0] ID_END_C  = 17'(ID_BYTES);
	localparam logic [16:0] ID2_END_C = 17'(2 * ID_BYTES);
	localparam logic [16:0] MAX_PAY_C = 17'(MAX_PAYLOAD);

	// configuration
	logic [7:0] begin_byte_q, end_byte_q, escape_byte_q;
	logic [7:0] begin_code_q, end_code_q, escape_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			begin_byte_q  <= efd_pkg::BEGIN_BYTE_RST;
			end_byte_q    <= efd_pkg::END_BYTE_RST;
			escape_byte_q <= efd_pkg::ESCAPE_BYTE_RST;
			begin_code_q  <= efd_pkg::BEGIN_CODE_RST;
			end_code_q    <= efd_pkg::END_CODE_RST;
			escape_code_q <= efd_pkg::ESCAPE_CODE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				efd_pkg::CFG_BEGIN_BYTE:  begin_byte_q  <= cfg_data;
				efd_pkg::CFG_END_BYTE:    end_byte_q    <= cfg_data;
				efd_pkg::CFG_ESCAPE_BYTE: escape_byte_q <= cfg_data;
				efd_pkg::CFG_BEGIN_CODE:  begin_code_q  <= cfg_data;
				efd_pkg::CFG_END_CODE:    end_code_q    <= cfg_data;
				efd_pkg::CFG_ESCAPE_CODE: escape_code_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	logic       advance;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	// frame state
	logic             in_frame_q, escape_q;
	logic [16:0]      count_q;
	logic [7:0]       sender_q, receiver_q;
	logic [15:0]      length_q;
	logic [31:0]      crc_q, rx_crc_q;
	efd_pkg::status_t error_q;

	logic             in_frame_d, escape_d;
	logic [16:0]      count_d;
	logic [7:0]       sender_d, receiver_d;
	logic [15:0]      length_d;
	logic [31:0]      crc_d, rx_crc_d;
	efd_pkg::status_t error_d;

	logic             emit;
	efd_pkg::kind_t   emit_kind;
	logic [7:0]       emit_data;
	efd_pkg::status_t emit_status;

	// end-of-frame status from the current state
	logic [16:0]      body_len, need_len;
	logic [31:0]      pad1, pad2, pad3, crc_padded;
	efd_pkg::status_t close_status;

	assign body_len = HDR_LEN_C + {1'b0, length_q};
	assign need_len = body_len + 17'd4;
	assign pad1 = efd_pkg::crc_byte(crc_q, 8'h00);
	assign pad2 = efd_pkg::crc_byte(pad1, 8'h00);
	assign pad3 = efd_pkg::crc_byte(pad2, 8'h00);

	always_comb begin
		// zero bytes up to the next multiple of four
		case (body_len[1:0])
			2'd1:    crc_padded = pad3;
			2'd2:    crc_padded = pad2;
			2'd3:    crc_padded = pad1;
			default: crc_padded = crc_q;
		endcase
		if (error_q != efd_pkg::ST_OK) close_status = error_q;
		else if (escape_q) close_status = efd_pkg::ST_BAD_ESC;
		else if (count_q < need_len) close_status = efd_pkg::ST_SHORT;
		else if (count_q > need_len) close_status = efd_pkg::ST_EXTRA;
		else if (crc_padded != rx_crc_q) close_status = efd_pkg::ST_CRC_BAD;
		else close_status = efd_pkg::ST_OK;
	end

	logic       have_d;
	logic [7:0] dec_byte;

	always_comb begin
		in_frame_d  = in_frame_q;
		escape_d    = escape_q;
		count_d     = count_q;
		sender_d    = sender_q;
		receiver_d  = receiver_q;
		length_d    = length_q;
		crc_d       = crc_q;
		rx_crc_d    = rx_crc_q;
		error_d     = error_q;
		emit        = 1'b0;
		emit_kind   = efd_pkg::KIND_DATA;
		emit_data   = 8'h00;
		emit_status = efd_pkg::ST_OK;
		have_d      = 1'b0;
		dec_byte    = byte_s1;

		if (!in_frame_q || byte_s1 == begin_byte_q) begin
			if (byte_s1 == begin_byte_q) begin
				if (in_frame_q) begin
					emit        = 1'b1;
					emit_kind   = efd_pkg::KIND_STATUS;
					emit_status = efd_pkg::ST_BEGIN;
				end
				in_frame_d = 1'b1;
				escape_d   = 1'b0;
				count_d    = '0;
				sender_d   = '0;
				receiver_d = '0;
				length_d   = '0;
				crc_d      = efd_pkg::CRC_INIT;
				rx_crc_d   = '0;
				error_d    = efd_pkg::ST_OK;
			end
		end else if (byte_s1 == end_byte_q) begin
			emit        = 1'b1;
			emit_kind   = efd_pkg::KIND_STATUS;
			emit_status = close_status;
			in_frame_d  = 1'b0;
			escape_d    = 1'b0;
		end else if (escape_q) begin
			escape_d = 1'b0;
			have_d   = 1'b1;
			if (byte_s1 == begin_code_q) dec_byte = begin_byte_q;
			else if (byte_s1 == end_code_q) dec_byte = end_byte_q;
			else if (byte_s1 == escape_code_q) dec_byte = escape_byte_q;
			else begin
				have_d = 1'b0;
				if (error_q == efd_pkg::ST_OK) error_d = efd_pkg::ST_BAD_ESC;
			end
		end else if (byte_s1 == escape_byte_q) begin
			escape_d = 1'b1;
		end else begin
			have_d = 1'b1;
		end

		// decoded byte: header, payload or trailing crc
		if (have_d && error_q == efd_pkg::ST_OK) begin
			if (count_q < HDR_LEN_C) begin
				crc_d = efd_pkg::crc_byte(crc_q, dec_byte);
				if (count_q < ID_END_C) sender_d = dec_byte;
				else if (count_q < ID2_END_C) receiver_d = dec_byte;
				else length_d = {length_q[7:0], dec_byte};
				if (count_q == HDR_LEN_C - 17'd1 && {1'b0, length_d} > MAX_PAY_C)
					error_d = efd_pkg::ST_TOO_LONG;
			end else if (count_q < body_len) begin
				crc_d     = efd_pkg::crc_byte(crc_q, dec_byte);
				emit      = 1'b1;
				emit_kind = efd_pkg::KIND_DATA;
				emit_data = dec_byte;
			end else begin
				rx_crc_d = {rx_crc_q[23:0], dec_byte};
			end
			if (count_q != efd_pkg::COUNT_MAX) count_d = count_q + 17'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			escape_q   <= 1'b0;
			count_q    <= '0;
			sender_q   <= '0;
			receiver_q <= '0;
			length_q   <= '0;
			crc_q      <= efd_pkg::CRC_INIT;
			rx_crc_q   <= '0;
			error_q    <= efd_pkg::ST_OK;
		end else if (advance) begin
			in_frame_q <= in_frame_d;
			escape_q   <= escape_d;
			count_q    <= count_d;
			sender_q   <= sender_d;
			receiver_q <= receiver_d;
			length_q   <= length_d;
			crc_q      <= crc_d;
			rx_crc_q   <= rx_crc_d;
			error_q    <= error_d;
		end
	end

	// result register
	logic             kind_q;
	logic [7:0]       data_q, sender_out_q, receiver_out_q;
	logic [15:0]      len_out_q;
	efd_pkg::status_t status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			kind_q         <= emit_kind;
			data_q         <= emit_data;
			sender_out_q   <= sender_q;
			receiver_out_q <= receiver_q;
			len_out_q      <= length_q;
			status_q       <= emit_status;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign data_byte   = data_q;
	assign sender_id   = sender_out_q;
	assign receiver_id = receiver_out_q;
	assign payload_len = len_out_q;
	assign status      = status_q;

	logic data_out, err_hold;

	assign data_out = out_valid_q && kind_q == efd_pkg::KIND_DATA;
	// an inner byte that neither opens nor closes the frame
	assign err_hold = advance && in_frame_q && error_q != efd_pkg::ST_OK
		&& byte_s1 != begin_byte_q && byte_s1 != end_byte_q;

	`EFD_ASSERT_IMPL(a_data_ok_status, clk, arst_n, data_out, status_q == efd_pkg::ST_OK)
	`EFD_ASSERT_IMPL(a_no_escape_outside, clk, arst_n, !in_frame_q, !escape_q)
	`EFD_ASSERT_NEXT(a_hunt_no_result, clk, arst_n, advance && !in_frame_q, !out_valid_q)
	`EFD_ASSERT_NEXT(a_error_sticky, clk, arst_n, err_hold, $stable(error_q))

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

	localparam int ID_LEN = efd_pkg::ID_BYTES_DEFAULT;
	localparam int PAYLOAD_MAX = efd_pkg::MAX_PAYLOAD_DEFAULT;
	localparam int HDR_BYTES = 2 * ID_LEN + 2;
	localparam int unsigned CYCLE_LIMIT = 3_000_000;
	localparam int PHASE_BYTES = 180;

	typedef struct {
		efd_pkg::kind_t   kind;
		logic [7:0]       data;
		logic [7:0]       sender;
		logic [7:0]       receiver;
		logic [15:0]      length;
		efd_pkg::status_t stat;
	} frame_result_t;

	typedef enum bit {OP_RAW, OP_REG} script_op_t;

	typedef struct packed {
		script_op_t          op;
		efd_pkg::cfg_index_t reg_sel;
		logic [7:0]          value;
		bit                  typed;
		efd_pkg::status_t    st;
	} script_row_t;

	// directed bytes and register writes, starting under the reset delimiters; a typed row fixes the status it closes with
	localparam script_row_t DIRECTED [28] = '{
		'{OP_RAW, efd_pkg::CFG_BEGIN_BYTE, 8'hFF, 1'b0, efd_pkg::ST_OK},
		'{OP_RAW, efd_pkg::CFG_BEGIN_BYTE, 8'h02, 1'b0, efd_pkg::ST_OK},
		'{OP_RAW, efd_pkg::CFG_BEGIN_BYTE, 8'h03, 1'b1, efd_pkg::ST_SHORT},
		'{OP_RAW, efd_pkg::CFG_BEGIN_BYTE, 8'h02, 1'b0, efd_pkg::ST_OK},
		'{OP_RAW, efd_pkg::CFG_BEGIN_BYTE, 8'h1B, 1'b0, efd_pkg::ST_OK},
		'{OP_RAW, efd_pkg::CFG_BEGIN_BYTE, 8'h00, 1'b0, efd_pkg::ST_OK},
		'{OP_RAW, efd_pkg::CFG_BEGIN_BYTE, 8'h03, 1'b1, efd_pkg::ST_BAD_ESC},
		'{OP_RAW, efd_pkg::CFG_BEGIN_BYTE, 8'h02, 1'b0, efd_pkg::ST_OK},
		'{OP_RAW, efd_pkg::CFG_BEGIN_BYTE, 8'h02, 1'b1, efd_pkg::ST_BEGIN},
		'{OP_RAW, efd_pkg::CFG_BEGIN_BYTE, 8'h1B, 1'b0, efd_pkg::ST_OK},
		'{OP_RAW, efd_pkg::CFG_BEGIN_BYTE, 8'h02, 1'b1, efd_pkg::ST_BEGIN},
		'{OP_RAW, efd_pkg::CFG_BEGIN_BYTE, 8'hFF, 1'b0, efd_pkg::ST_OK},
		'{OP_RAW, efd_pkg::CFG_BEGIN_BYTE, 8'h00, 1'b0, efd_pkg::ST_OK},
		'{OP_RAW, efd_pkg::CFG_BEGIN_BYTE, 8'h04, 1'b0, efd_pkg::ST_OK},
		'{OP_RAW, efd_pkg::CFG_BEGIN_BYTE, 8'h01, 1'b0, efd_pkg::ST_OK},
		'{OP_RAW, efd_pkg::CFG_BEGIN_BYTE, 8'h03, 1'b1, efd_pkg::ST_TOO_LONG},
		'{OP_RAW, efd_pkg::CFG_BEGIN_BYTE, 8'h02, 1'b0, efd_pkg::ST_OK},
		'{OP_RAW, efd_pkg::CFG_BEGIN_BYTE, 8'h1B, 1'b0, efd_pkg::ST_OK},
		'{OP_RAW, efd_pkg::CFG_BEGIN_BYTE, 8'h03, 1'b1, efd_pkg::ST_BAD_ESC},
		'{OP_REG, efd_pkg::CFG_END_BYTE,   8'h02, 1'b0, efd_pkg::ST_OK},
		'{OP_RAW, efd_pkg::CFG_BEGIN_BYTE, 8'h02, 1'b0, efd_pkg::ST_OK},
		'{OP_RAW, efd_pkg::CFG_BEGIN_BYTE, 8'h02, 1'b1, efd_pkg::ST_BEGIN},
		'{OP_REG, efd_pkg::CFG_END_BYTE,   8'h03, 1'b0, efd_pkg::ST_OK},
		'{OP_REG, efd_pkg::CFG_END_CODE,   8'd34, 1'b0, efd_pkg::ST_OK},
		'{OP_RAW, efd_pkg::CFG_BEGIN_BYTE, 8'h1B, 1'b0, efd_pkg::ST_OK},
		'{OP_RAW, efd_pkg::CFG_BEGIN_BYTE, 8'h22, 1'b0, efd_pkg::ST_OK},
		'{OP_RAW, efd_pkg::CFG_BEGIN_BYTE, 8'h03, 1'b1, efd_pkg::ST_SHORT},
		'{OP_REG, efd_pkg::CFG_END_CODE,   8'd35, 1'b0, efd_pkg::ST_OK}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = efd_pkg::CFG_BEGIN_BYTE;
	logic [7:0]  cfg_data = 8'h00;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  in_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        kind;
	logic [7:0]  data_byte;
	logic [7:0]  sender_id;
	logic [7:0]  receiver_id;
	logic [15:0] payload_len;
	logic [2:0]  status;

	// travels with in_byte: expected status typed into the directed table
	bit               in_typed = 1'b0;
	efd_pkg::status_t in_typed_st = efd_pkg::ST_OK;

	bit          idle_on;
	int unsigned stall_left;
	int unsigned cycle_count;
	int unsigned mismatches;
	int unsigned results_seen;
	int unsigned frame_bytes_sent;
	int unsigned frames_sent;

	frame_result_t awaited_results [$];

	// deframer state as the testbench sees it
	logic [7:0]       cfg_val [efd_pkg::NUM_CFG];
	bit               p_in_frame;
	bit               p_esc;
	logic [16:0]      p_count;
	logic [7:0]       p_sender;
	logic [7:0]       p_receiver;
	logic [15:0]      p_len;
	logic [31:0]      p_crc;
	logic [31:0]      p_rx_crc;
	efd_pkg::status_t latched_err;

	escaped_frame_deframer_crc_check uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.data_byte(data_byte),
		.sender_id(sender_id),
		.receiver_id(receiver_id),
		.payload_len(payload_len),
		.status(status)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// bit-serial crc-32/mpeg-2, msb first
	function automatic logic [31:0] crc32_mpeg2_step(input logic [31:0] acc,
			input logic [7:0] b);
		int i;
		for (i = 7; i >= 0; i--)
			acc = {acc[30:0], 1'b0} ^ ((acc[31] ^ b[i]) ? efd_pkg::CRC_POLY : 32'h0);
		return acc;
	endfunction

	function automatic void start_frame();
		p_in_frame = 1'b1;
		p_esc = 1'b0;
		p_count = '0;
		p_sender = 8'h00;
		p_receiver = 8'h00;
		p_len = 16'h0000;
		p_crc = efd_pkg::CRC_INIT;
		p_rx_crc = 32'h0;
		latched_err = efd_pkg::ST_OK;
	endfunction

	function automatic efd_pkg::status_t closing_status();
		int body;
		int need;
		int k;
		logic [31:0] acc;
		body = HDR_BYTES + int'(p_len);
		need = body + 4;
		if (latched_err != efd_pkg::ST_OK)
			return latched_err;
		if (p_esc)
			return efd_pkg::ST_BAD_ESC;
		if (int'(p_count) < need)
			return efd_pkg::ST_SHORT;
		if (int'(p_count) > need)
			return efd_pkg::ST_EXTRA;
		acc = p_crc;
		// zero fill up to a whole word
		for (k = body % 4; k != 0 && k < 4; k++)
			acc = crc32_mpeg2_step(acc, 8'h00);
		return (acc == p_rx_crc) ? efd_pkg::ST_OK : efd_pkg::ST_CRC_BAD;
	endfunction

	function automatic bit absorb_decoded(input logic [7:0] b);
		int pos;
		bit emit;
		pos = int'(p_count);
		emit = 1'b0;
		if (latched_err != efd_pkg::ST_OK)
			return 1'b0;
		if (pos < HDR_BYTES) begin
			p_crc = crc32_mpeg2_step(p_crc, b);
			if (pos < ID_LEN)
				p_sender = b;
			else if (pos < 2 * ID_LEN)
				p_receiver = b;
			else
				p_len = {p_len[7:0], b};
			if (pos == HDR_BYTES - 1 && int'(p_len) > PAYLOAD_MAX)
				latched_err = efd_pkg::ST_TOO_LONG;
		end else if (pos < HDR_BYTES + int'(p_len)) begin
			p_crc = crc32_mpeg2_step(p_crc, b);
			emit = 1'b1;
		end else begin
			p_rx_crc = {p_rx_crc[23:0], b};
		end
		if (p_count != efd_pkg::COUNT_MAX)
			p_count = p_count + 17'd1;
		return emit;
	endfunction

	function automatic bit deframe_byte(input logic [7:0] b, output frame_result_t r);
		logic [7:0] d;
		r = '{efd_pkg::KIND_DATA, 8'h00, p_sender, p_receiver, p_len, efd_pkg::ST_OK};
		if (!p_in_frame) begin
			if (b == cfg_val[efd_pkg::CFG_BEGIN_BYTE])
				start_frame();
			return 1'b0;
		end
		if (b == cfg_val[efd_pkg::CFG_BEGIN_BYTE]) begin
			r.kind = efd_pkg::KIND_STATUS;
			r.stat = efd_pkg::ST_BEGIN;
			start_frame();
			return 1'b1;
		end
		if (b == cfg_val[efd_pkg::CFG_END_BYTE]) begin
			r.kind = efd_pkg::KIND_STATUS;
			r.stat = closing_status();
			p_in_frame = 1'b0;
			p_esc = 1'b0;
			return 1'b1;
		end
		if (p_esc) begin
			p_esc = 1'b0;
			if (b == cfg_val[efd_pkg::CFG_BEGIN_CODE])
				d = cfg_val[efd_pkg::CFG_BEGIN_BYTE];
			else if (b == cfg_val[efd_pkg::CFG_END_CODE])
				d = cfg_val[efd_pkg::CFG_END_BYTE];
			else if (b == cfg_val[efd_pkg::CFG_ESCAPE_CODE])
				d = cfg_val[efd_pkg::CFG_ESCAPE_BYTE];
			else begin
				if (latched_err == efd_pkg::ST_OK)
					latched_err = efd_pkg::ST_BAD_ESC;
				return 1'b0;
			end
		end else if (b == cfg_val[efd_pkg::CFG_ESCAPE_BYTE]) begin
			p_esc = 1'b1;
			return 1'b0;
		end else begin
			d = b;
		end
		if (absorb_decoded(d)) begin
			r.data = d;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		mismatches++;
		$display("[%0t] %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
	endtask

	always @(posedge clk) begin : scoreboard
		frame_result_t fresh;
		frame_result_t want;
		bit got;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				got = deframe_byte(in_byte, fresh);
				if (in_typed) begin
					fresh.kind = efd_pkg::KIND_STATUS;
					fresh.data = 8'h00;
					fresh.stat = in_typed_st;
					got = 1'b1;
				end
				if (got)
					awaited_results.insert(awaited_results.size(), fresh);
			end
			if (out_valid && out_ready) begin
				results_seen++;
				if (awaited_results.size() == 0) begin
					report_mismatch("result transfer with nothing awaited, status", status, 0);
				end else begin
					want = awaited_results.pop_front();
					if (kind !== want.kind)
						report_mismatch("kind", kind, want.kind);
					if (data_byte !== want.data)
						report_mismatch("data_byte", data_byte, want.data);
					if (sender_id !== want.sender)
						report_mismatch("sender_id", sender_id, want.sender);
					if (receiver_id !== want.receiver)
						report_mismatch("receiver_id", receiver_id, want.receiver);
					if (payload_len !== want.length)
						report_mismatch("payload_len", payload_len, want.length);
					if (status !== want.stat)
						report_mismatch("status", status, want.stat);
				end
			end
		end
	end

	// receiver side: random stall bursts while idling is on
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 6) == 0) begin
			stall_left <= $urandom_range(0, 10);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				awaited_results.size());
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic push_raw(input logic [7:0] b, input bit typed, input efd_pkg::status_t st);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		in_typed <= typed;
		in_typed_st <= st;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// let every awaited result drain, then cover bytes still in the pipe
	task automatic wait_drained();
		in_valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input efd_pkg::cfg_index_t idx, input logic [7:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		cfg_val[idx] = v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_delimiters(input logic [7:0] bb, input logic [7:0] eb,
			input logic [7:0] xb, input logic [7:0] bc, input logic [7:0] ec,
			input logic [7:0] xc);
		wait_drained();
		write_reg(efd_pkg::CFG_BEGIN_BYTE, bb);
		write_reg(efd_pkg::CFG_END_BYTE, eb);
		write_reg(efd_pkg::CFG_ESCAPE_BYTE, xb);
		write_reg(efd_pkg::CFG_BEGIN_CODE, bc);
		write_reg(efd_pkg::CFG_END_CODE, ec);
		write_reg(efd_pkg::CFG_ESCAPE_CODE, xc);
	endtask

	// builds one frame, optionally damages it, stuffs it and sends it
	task automatic send_frame(input bit mangle, input int fixed_len);
		logic [7:0] dec [$];
		logic [7:0] raw [$];
		logic [31:0] acc;
		int len;
		int pos;
		int i;
		int sel;
		int damage;
		bit too_long;
		if (fixed_len >= 0) begin
			len = fixed_len;
		end else begin
			sel = $urandom_range(0, 99);
			if (sel < 80)
				len = $urandom_range(0, 24);
			else if (sel < 93)
				len = $urandom_range(25, 120);
			else if (sel < 99)
				len = $urandom_range(PAYLOAD_MAX + 1, 65535);
			else
				len = 65535;
		end
		too_long = len > PAYLOAD_MAX;
		repeat (2 * ID_LEN) dec.insert(dec.size(), 8'($urandom_range(0, 255)));
		dec.insert(dec.size(), 8'(len >> 8));
		dec.insert(dec.size(), 8'(len));
		if (!too_long) begin
			repeat (len) dec.insert(dec.size(), 8'($urandom_range(0, 255)));
			acc = efd_pkg::CRC_INIT;
			foreach (dec[j])
				acc = crc32_mpeg2_step(acc, dec[j]);
			for (i = dec.size() % 4; i != 0 && i < 4; i++)
				acc = crc32_mpeg2_step(acc, 8'h00);
			for (i = 3; i >= 0; i--)
				dec.insert(dec.size(), acc[8 * i +: 8]);
		end else begin
			repeat ($urandom_range(0, 3)) dec.insert(dec.size(), 8'($urandom_range(0, 255)));
		end
		damage = mangle ? $urandom_range(0, 7) : -1;
		if (damage == 0) begin
			pos = $urandom_range(0, dec.size() - 1);
			dec[pos] = dec[pos] ^ 8'(1 << $urandom_range(0, 7));
		end else if (damage == 1) begin
			dec.insert(dec.size(), 8'($urandom_range(0, 255)));
		end
		raw.insert(raw.size(), cfg_val[efd_pkg::CFG_BEGIN_BYTE]);
		foreach (dec[j]) begin
			if (dec[j] == cfg_val[efd_pkg::CFG_BEGIN_BYTE]) begin
				raw.insert(raw.size(), cfg_val[efd_pkg::CFG_ESCAPE_BYTE]);
				raw.insert(raw.size(), cfg_val[efd_pkg::CFG_BEGIN_CODE]);
			end else if (dec[j] == cfg_val[efd_pkg::CFG_END_BYTE]) begin
				raw.insert(raw.size(), cfg_val[efd_pkg::CFG_ESCAPE_BYTE]);
				raw.insert(raw.size(), cfg_val[efd_pkg::CFG_END_CODE]);
			end else if (dec[j] == cfg_val[efd_pkg::CFG_ESCAPE_BYTE]) begin
				raw.insert(raw.size(), cfg_val[efd_pkg::CFG_ESCAPE_BYTE]);
				raw.insert(raw.size(), cfg_val[efd_pkg::CFG_ESCAPE_CODE]);
			end else begin
				raw.insert(raw.size(), dec[j]);
			end
		end
		pos = $urandom_range(1, raw.size() - 1);
		case (damage)
			2: raw.delete(pos);
			3: raw.insert(pos, 8'($urandom_range(0, 255)));
			4: begin
				raw.insert(pos, 8'($urandom_range(0, 255)));
				raw.insert(pos, cfg_val[efd_pkg::CFG_ESCAPE_BYTE]);
			end
			5: raw.insert(pos, cfg_val[efd_pkg::CFG_BEGIN_BYTE]);
			6: raw.insert(raw.size(), cfg_val[efd_pkg::CFG_ESCAPE_BYTE]);
			7: while (raw.size() > pos) void'(raw.pop_back());
			default: ;
		endcase
		raw.insert(raw.size(), cfg_val[efd_pkg::CFG_END_BYTE]);
		foreach (raw[j])
			push_raw(raw[j], 1'b0, efd_pkg::ST_OK);
		frame_bytes_sent += raw.size();
		frames_sent++;
	endtask

	task automatic random_frames(input int budget);
		int unsigned target;
		target = frame_bytes_sent + budget;
		while (frame_bytes_sent < target) begin
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3)) push_raw(8'($urandom()), 1'b0, efd_pkg::ST_OK);
			send_frame($urandom_range(0, 4) == 0, -1);
		end
	endtask

	initial begin : stimulus
		logic [7:0] pick [6];
		bit clash;
		int i;
		int j;
		cfg_val[efd_pkg::CFG_BEGIN_BYTE] = efd_pkg::BEGIN_BYTE_RST;
		cfg_val[efd_pkg::CFG_END_BYTE] = efd_pkg::END_BYTE_RST;
		cfg_val[efd_pkg::CFG_ESCAPE_BYTE] = efd_pkg::ESCAPE_BYTE_RST;
		cfg_val[efd_pkg::CFG_BEGIN_CODE] = efd_pkg::BEGIN_CODE_RST;
		cfg_val[efd_pkg::CFG_END_CODE] = efd_pkg::END_CODE_RST;
		cfg_val[efd_pkg::CFG_ESCAPE_CODE] = efd_pkg::ESCAPE_CODE_RST;
		start_frame();
		p_in_frame = 1'b0;
		idle_on = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[k]) begin
			if (DIRECTED[k].op == OP_REG) begin
				wait_drained();
				write_reg(DIRECTED[k].reg_sel, DIRECTED[k].value);
			end else begin
				push_raw(DIRECTED[k].value, DIRECTED[k].typed, DIRECTED[k].st);
			end
		end

		random_frames(PHASE_BYTES);

		load_delimiters(8'h00, 8'hFF, 8'h7E, 8'h01, 8'hFE, 8'h5D);
		random_frames(PHASE_BYTES);

		load_delimiters(8'hFF, 8'h00, 8'h01, 8'h80, 8'h7F, 8'hFE);
		random_frames(PHASE_BYTES);

		// six distinct random delimiters, no idling on either side from here on
		for (i = 0; i < 6; i++) begin
			do begin
				pick[i] = 8'($urandom_range(0, 255));
				clash = 1'b0;
				for (j = 0; j < i; j++)
					if (pick[j] == pick[i])
						clash = 1'b1;
			end while (clash);
		end
		load_delimiters(pick[0], pick[1], pick[2], pick[3], pick[4], pick[5]);
		idle_on = 1'b0;
		send_frame(1'b0, PAYLOAD_MAX);
		random_frames(PHASE_BYTES);

		wait_drained();
		$display("%0d frames in %0d bytes over four delimiter sets, plus the directed rows",
			frames_sent, frame_bytes_sent);
		$display("%0d result transfers compared, %0d mismatches", results_seen, mismatches);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/efd_pkg.sv
rtl/core/escaped_frame_deframer_crc_check.sv
test/testbench.sv
